/* sv/assert_macros.svh */
// assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, skipped while reset is high
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, skipped while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// same-cycle implication that also holds through reset
`define ASSERT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |-> (cons)) \
      else $error("assertion failed");

`endif

/* sv/clc_pkg.sv */
// shared types and codes for the deque block
package clc_pkg;

   localparam int DATA_W = 32;

   typedef enum logic [2:0] {
      CMD_PUSH_BACK  = 3'd0,
      CMD_PUSH_FRONT = 3'd1,
      CMD_POP_BACK   = 3'd2,
      CMD_POP_FRONT  = 3'd3,
      CMD_READ_ALL   = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // what every cell does at each clock edge
   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_APPEND,
      CELL_SHIFT_UP,
      CELL_SHIFT_DOWN,
      CELL_ROTATE
   } cell_op_type;

endpackage

/* sv/clc_cell.sv */
// one storage cell of the deque chain
module clc_cell
   import clc_pkg::*;
#(
   parameter int IW  = 6,
   parameter int IDX = 0
) (
   input  logic              clock,
   input  cell_op_type       op,
   input  logic [IW-1:0]     sel_idx,
   input  logic [DATA_W-1:0] new_value,
   input  logic [DATA_W-1:0] left_value,
   input  logic [DATA_W-1:0] right_value,
   input  logic [DATA_W-1:0] head_value,
   output logic [DATA_W-1:0] data
);

   localparam logic [IW-1:0] MY_IDX = IW'(IDX);

   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;
   logic              hit;

   assign hit  = (sel_idx == MY_IDX);
   assign data = data_ff;

   always_comb begin
      data_in = data_ff;
      case (op)
         CELL_APPEND:     data_in = hit ? new_value : data_ff;
         CELL_SHIFT_UP:   data_in = left_value;
         CELL_SHIFT_DOWN: data_in = right_value;
         // the front element wraps into the last occupied cell
         CELL_ROTATE:     data_in = hit ? head_value : right_value;
         default:         data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

/* sv/clc_seq.sv */
// command sequencer, element count and result register of the deque
module clc_seq
   import clc_pkg::*;
#(
   parameter int CAPACITY = 64,
   parameter int IW       = 6
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [2:0]        req_tuser,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [DATA_W-1:0] rsp_tdata,
   output logic [1:0]        rsp_tuser,
   output logic              rsp_tlast,
   input  logic [DATA_W-1:0] head_value,
   output cell_op_type       cell_op,
   output logic [IW-1:0]     sel_idx
);

   localparam int            CW      = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);
   localparam logic [CW-1:0] ONE     = CW'(1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_ROTATE,
      S_POP,
      S_READ
   } state_type;

   state_type         state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     rem_ff, rem_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              out_free;
   logic              accept;
   logic [CW-1:0]     cnt_m1;
   logic              empty;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && out_free;
   assign accept     = req_tvalid && req_tready;
   assign cnt_m1     = count_ff - ONE;
   assign empty      = (count_ff == '0);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      rem_in        = rem_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;
      cell_op       = CELL_HOLD;
      sel_idx       = count_ff[IW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_tuser)
                  CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = '0;
                     rsp_last_in  = 1'b1;
                     if (count_ff == CAP_CNT) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        rsp_status_in = ST_OK;
                        count_in      = count_ff + ONE;
                        cell_op       = (req_tuser == CMD_PUSH_BACK) ? CELL_APPEND
                                                                     : CELL_SHIFT_UP;
                     end
                  end
                  CMD_POP_BACK, CMD_POP_FRONT: begin
                     if (empty) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_EMPTY;
                        rsp_data_in   = '0;
                        rsp_last_in   = 1'b1;
                     end else if (req_tuser == CMD_POP_FRONT || count_ff == ONE) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_OK;
                        rsp_data_in   = head_value;
                        rsp_last_in   = 1'b1;
                        count_in      = cnt_m1;
                        cell_op       = CELL_SHIFT_DOWN;
                     end else begin
                        // bring the back element to the front, then pop it
                        state_in = S_ROTATE;
                        rem_in   = cnt_m1;
                     end
                  end
                  CMD_READ_ALL: begin
                     if (empty) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_EMPTY;
                        rsp_data_in   = '0;
                        rsp_last_in   = 1'b1;
                     end else begin
                        state_in = S_READ;
                        rem_in   = count_ff;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_ROTATE: begin
            cell_op = CELL_ROTATE;
            sel_idx = cnt_m1[IW-1:0];
            rem_in  = rem_ff - ONE;
            if (rem_ff == ONE) begin
               state_in = S_POP;
            end
         end
         S_POP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_data_in   = head_value;
               rsp_last_in   = 1'b1;
               count_in      = cnt_m1;
               cell_op       = CELL_SHIFT_DOWN;
               state_in      = S_IDLE;
            end
         end
         S_READ: begin
            // a full turn of the ring leaves the order as it was
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_data_in   = head_value;
               rsp_last_in   = (rem_ff == ONE);
               cell_op       = CELL_ROTATE;
               sel_idx       = cnt_m1[IW-1:0];
               rem_in        = rem_ff - ONE;
               if (rem_ff == ONE) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rem_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rem_ff       <= rem_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_last_ff   <= rsp_last_in;
   end

endmodule

/* sv/circular_list_deque.sv */
// top level of the deque: a row of storage cells steered by one sequencer
//
//   channel  direction  tdata            tuser         tlast
//   req      in         value[31:0]      command[2:0]  -
//   rsp      out        value_res[31:0]  status[1:0]   last
//
// push and pop front are handled without leaving idle; one item per cycle while rsp is drained
// pop back rotates the row count-1 times, then pops; with count 1 it pops without rotating
// read all moves the row one cell per result and stalls while rsp_tready is low
// reset clears count and control; cell contents are not cleared
// rsp_tready low holds the result register; only the pop back rotation keeps moving
module circular_list_deque
   import clc_pkg::*;
#(
   parameter int CAPACITY = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [DATA_W-1:0] req_tdata,   // value[31:0]
   input  logic [2:0]        req_tuser,   // command[2:0]
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [DATA_W-1:0] rsp_tdata,   // value_res[31:0]
   output logic [1:0]        rsp_tuser,   // status[1:0]
   output logic              rsp_tlast
);

   localparam int IW = $clog2(CAPACITY);

   cell_op_type       cell_op;
   logic [IW-1:0]     sel_idx;
   logic [DATA_W-1:0] cell_data [CAPACITY];

   clc_seq #(
      .CAPACITY(CAPACITY),
      .IW      (IW)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast),
      .head_value(cell_data[0]),
      .cell_op   (cell_op),
      .sel_idx   (sel_idx)
   );

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_W-1:0] left_v;
      logic [DATA_W-1:0] right_v;

      if (i == 0) begin : g_first
         assign left_v = req_tdata;
      end else begin : g_mid_l
         assign left_v = cell_data[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_v = cell_data[i];
      end else begin : g_mid_r
         assign right_v = cell_data[i+1];
      end

      clc_cell #(
         .IW (IW),
         .IDX(i)
      ) u_cell (
         .clock      (clock),
         .op         (cell_op),
         .sel_idx    (sel_idx),
         .new_value  (req_tdata),
         .left_value (left_v),
         .right_value(right_v),
         .head_value (cell_data[0]),
         .data       (cell_data[i])
      );
   end

endmodule

/* sv/clc_checker.sv */
// port-level checks for the deque, bound to the top level
`include "assert_macros.svh"

module clc_checker
   import clc_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // a result stays put until it is taken
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))

   // a failed command gives one result, zero data
   `ASSERT_IMPLY(a_err_single, clock, reset, rsp_tvalid && rsp_tuser != ST_OK, rsp_tlast && rsp_tdata == '0)

   // no new command is taken while a read-all run is still going
   `ASSERT_IMPLY(a_run_blocks, clock, reset, rsp_tvalid && !rsp_tlast, !req_tready)

   `ASSERT_IMPLY(a_status_code, clock, reset, rsp_tvalid, rsp_tuser == ST_OK || rsp_tuser == ST_EMPTY || rsp_tuser == ST_FULL)

   // nothing is offered right after reset
   `ASSERT_ALWAYS(a_reset_quiet, clock, $past(reset), !rsp_tvalid)

endmodule

bind circular_list_deque clc_checker u_clc_checker (.*);

/* tb/testbench.sv */
// testbench for circular_list_deque: directed and random command streams checked against a ring-buffer predictor
`timescale 1ns / 100ps

module testbench;
   import clc_pkg::*;

   localparam int CAPACITY = 64;
   localparam int RANDOM_ITEMS = 145;
   localparam int CYCLE_LIMIT = 500000;
   localparam int DRAIN_CYCLES = 2 * CAPACITY + 16;
   localparam int MAX_REPORTS = 10;

   typedef struct {
      status_type  status;
      logic [31:0] value;
      logic        last;
   } deque_rsp_type;

   class deque_scoreboard;
      logic [31:0]   ring [CAPACITY];
      int unsigned   head;
      int unsigned   count;
      deque_rsp_type expected_rsps [$];
      int            errors;
      int            requests;
      int            responses;
      int            full_drops;
      int            empty_hits;
      int unsigned   peak;

      function new();
         head = 0;
         count = 0;
         errors = 0;
         requests = 0;
         responses = 0;
         full_drops = 0;
         empty_hits = 0;
         peak = 0;
      endfunction

      function void add_rsp(status_type status, logic [31:0] value, logic last);
         deque_rsp_type r;
         r.status = status;
         r.value = value;
         r.last = last;
         expected_rsps.push_back(r);
      endfunction

      // predict the responses of one accepted request
      function void note_request(logic [2:0] cmd, logic [31:0] value);
         int unsigned pos;
         requests++;
         case (cmd)
            CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
               if (count >= CAPACITY) begin
                  full_drops++;
                  add_rsp(ST_FULL, '0, 1'b1);
               end else begin
                  if (cmd == CMD_PUSH_BACK) begin
                     ring[(head + count) % CAPACITY] = value;
                  end else begin
                     head = (head + CAPACITY - 1) % CAPACITY;
                     ring[head] = value;
                  end
                  count++;
                  if (count > peak) peak = count;
                  add_rsp(ST_OK, '0, 1'b1);
               end
            end
            CMD_POP_BACK, CMD_POP_FRONT: begin
               if (count == 0) begin
                  empty_hits++;
                  add_rsp(ST_EMPTY, '0, 1'b1);
               end else begin
                  if (cmd == CMD_POP_BACK) begin
                     pos = (head + count - 1) % CAPACITY;
                  end else begin
                     pos = head;
                     head = (head + 1) % CAPACITY;
                  end
                  count--;
                  add_rsp(ST_OK, ring[pos], 1'b1);
               end
            end
            CMD_READ_ALL: begin
               if (count == 0) begin
                  empty_hits++;
                  add_rsp(ST_EMPTY, '0, 1'b1);
               end else begin
                  for (int unsigned i = 0; i < count; i++)
                     add_rsp(ST_OK, ring[(head + i) % CAPACITY], (i + 1 == count));
               end
            end
            default: ;  // unknown commands are dropped without a response
         endcase
      endfunction

      function void report(string field, logic [31:0] want, logic [31:0] got);
         errors++;
         if (errors <= MAX_REPORTS)
            $display("mismatch on %s at response %0d: expected %h, got %h",
                     field, responses, want, got);
      endfunction

      function void check_response(logic [1:0] status, logic [31:0] value, logic last);
         deque_rsp_type r;
         responses++;
         if (expected_rsps.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("unexpected response transfer: status %0d value %h last %b",
                        status, value, last);
         end else begin
            r = expected_rsps.pop_front();
            if (status !== r.status) report("status", r.status, status);
            if (value !== r.value) report("value", r.value, value);
            if (last !== r.last) report("last", r.last, last);
         end
      endfunction

      function int pending();
         return expected_rsps.size();
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [DATA_W-1:0] req_tdata;
   logic [2:0]        req_tuser;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [DATA_W-1:0] rsp_tdata;
   logic [1:0]        rsp_tuser;
   logic              rsp_tlast;

   deque_scoreboard sb;
   int send_idle_pct;
   int recv_idle_pct;
   int cycles = 0;

   circular_list_deque #(.CAPACITY(CAPACITY)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   initial begin
      sb = new();
   end

   // watch both channels at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_request(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready) sb.check_response(rsp_tuser, rsp_tdata, rsp_tlast);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d responses outstanding",
                  cycles, sb.pending());
         $display("Test completed with failures");
         $finish;
      end
   end

   // receiver back-pressure
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic send_item(logic [2:0] cmd, logic [31:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(19))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'h0000_0000;
         3: return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [2:0] pick_push();
      return $urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
   endfunction

   function automatic logic [2:0] pick_pop();
      return $urandom_range(1) ? CMD_POP_FRONT : CMD_POP_BACK;
   endfunction

   // fill early, churn in the middle, drain at the end
   function automatic logic [2:0] pick_command(int idx);
      int roll;
      roll = $urandom_range(99);
      if (idx < 80) begin
         if (roll < 95) return pick_push();
         else if (roll < 97) return pick_pop();
         else return CMD_READ_ALL;
      end else if (idx < 100) begin
         case ($urandom_range(4))
            0: return CMD_PUSH_BACK;
            1: return CMD_PUSH_FRONT;
            2: return CMD_POP_BACK;
            3: return CMD_POP_FRONT;
            default: return CMD_READ_ALL;
         endcase
      end else begin
         if (roll < 85) return pick_pop();
         else if (roll < 93) return pick_push();
         else return CMD_READ_ALL;
      end
   endfunction

   initial begin
      int idx;
      int wait_cycles;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      send_idle_pct = 17;
      recv_idle_pct = 73;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty queue, extreme values, both ends, unknown commands
      send_item(CMD_READ_ALL, 32'h1234_5678);
      send_item(CMD_POP_BACK, 32'hffff_ffff);
      send_item(CMD_POP_FRONT, 32'h0);
      send_item(CMD_PUSH_BACK, 32'h7fff_ffff);
      send_item(CMD_PUSH_FRONT, 32'h8000_0000);
      send_item(CMD_PUSH_BACK, 32'h0000_0000);
      send_item(CMD_PUSH_FRONT, 32'hffff_ffff);
      send_item(CMD_READ_ALL, 32'h0);
      send_item(CMD_POP_BACK, 32'h0);
      send_item(CMD_POP_FRONT, 32'h0);
      send_item(3'd5, 32'hdead_beef);
      send_item(3'd6, 32'h0);
      send_item(3'd7, 32'hffff_ffff);
      send_item(CMD_READ_ALL, 32'h0);
      send_item(CMD_POP_FRONT, 32'h0);
      send_item(CMD_POP_BACK, 32'h0);
      send_item(CMD_POP_FRONT, 32'h0);
      send_item(CMD_PUSH_FRONT, 32'haaaa_aaaa);
      send_item(CMD_PUSH_BACK, 32'h5555_5555);
      send_item(CMD_READ_ALL, 32'h0);
      send_item(CMD_POP_BACK, 32'h0);
      send_item(CMD_POP_BACK, 32'h0);
      send_item(CMD_POP_BACK, 32'h0);

      idx = 0;
      while (idx < RANDOM_ITEMS) begin
         if (idx < RANDOM_ITEMS / 3) begin
            send_idle_pct = 17;
            recv_idle_pct = 73;
         end else if (idx < 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct = 73;
            recv_idle_pct = 17;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         // occasional noise the block should ignore
         if ($urandom_range(99) < 3) begin
            send_item(3'($urandom_range(7, 5)), $urandom);
         end else begin
            send_item(pick_command(idx), pick_value());
            idx++;
         end
      end
      req_tvalid <= 1'b0;
      send_idle_pct = 0;
      recv_idle_pct = 0;

      while (sb.pending() != 0) @(posedge clock);
      // stray transfers after the last expected one count as failures
      wait_cycles = 0;
      while (wait_cycles < DRAIN_CYCLES) begin
         @(posedge clock);
         wait_cycles++;
      end

      $display("%0d requests and %0d responses checked, queue depth peaked at %0d of %0d",
               sb.requests, sb.responses, sb.peak, CAPACITY);
      $display("%0d pushes dropped on a full queue, %0d pops or reads on an empty one",
               sb.full_drops, sb.empty_hits);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("%0d mismatches, %0d responses outstanding", sb.errors, sb.pending());
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
